FILE: src/kvl_pkg.sv
package kvl_pkg;

    // table geometry
    localparam int MAX_KEYS = 64;
    localparam int KEY_IW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KEY_CW   = $clog2(MAX_KEYS + 1);

    // divider geometry: |dtq| << 16 over |dt|
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW);

    // opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_ZERO_INT = 3'd3;
    localparam logic [2:0] ST_SAT      = 3'd4;

    // axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // multiply phases of one axis
    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_ACC = 2'd2;
    localparam logic [1:0] PH_FIN = 2'd3;

    typedef struct packed {
        logic [31:0]        ktime;
        logic signed [31:0] kx;
        logic signed [31:0] ky;
        logic signed [31:0] kz;
    } t_key;

    typedef struct packed {
        logic               opcode;
        logic [31:0]        time_req;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         segment;
        logic [2:0]         status;
    } t_res;

    typedef struct packed {
        logic              shift;
        logic              load;
        logic [KEY_IW-1:0] idx;
        t_key              data;
    } t_chain_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_PREP,
        S_DIV,
        S_MUL
    } t_state;

endpackage

FILE: src/keyframe_vec3_lerp_top.sv
// Channel  | Ports                      | Handshake
// command  | start, busy, i_cmd         | beat taken when start is high and busy low
// result   | o_strobe, o_res            | beat valid for one cycle, always taken
//
// An append is taken from idle; its result strobes the next cycle and busy stays low.
// A sample on zero or one key also strobes its result the next cycle. Otherwise busy
// stays high while the key ring rotates past the head, for set-up, in the bit-serial
// divider and in the shared 32x24 multiplier; a zero interval skips the last two. The
// result strobes in the cycle busy falls. Reset (synchronous, active low) empties the
// table; cells themselves hold no reset. Results cannot be stalled.
module keyframe_vec3_lerp_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  kvl_pkg::t_cmd   i_cmd,
    output logic            o_strobe,
    output kvl_pkg::t_res   o_res
);

    kvl_pkg::t_state            r_state;
    kvl_pkg::t_state            n_state;
    logic [kvl_pkg::KEY_CW-1:0] r_count;
    logic [kvl_pkg::KEY_IW-1:0] r_cnt;
    logic [kvl_pkg::KEY_IW-1:0] r_seg;
    logic                       r_found;
    logic [31:0]                r_t;
    kvl_pkg::t_key              r_prev;
    kvl_pkg::t_key              r_p0;
    kvl_pkg::t_key              r_p1;
    logic                       r_negf;
    logic [kvl_pkg::DIV_NW-1:0] r_b;
    logic [1:0]                 r_ax;
    logic [1:0]                 r_ph;
    logic [55:0]                r_pp;
    logic [79:0]                r_acc;
    logic                       r_sat;
    logic                       r_strobe;
    kvl_pkg::t_res              r_res;
    kvl_pkg::t_res              n_res;

    kvl_pkg::t_chain_ctl        chain_ctl;
    kvl_pkg::t_key              head;
    logic                       div_start;
    logic                       div_done;
    logic [kvl_pkg::DIV_NW-1:0] div_quo;
    logic                       accept;
    logic                       rot_last;
    logic                       cnt_last;
    logic signed [32:0]         dt;
    logic signed [32:0]         dtq;
    logic [31:0]                dt_mag;
    logic [31:0]                dtq_mag;
    logic signed [31:0]         ax_p0;
    logic signed [31:0]         ax_p1;
    logic signed [32:0]         ax_d;
    logic [31:0]                ax_a;
    logic                       ax_neg;
    logic [23:0]                mul_b;
    logic                       fin_big;
    logic signed [41:0]         fin_sum;
    logic signed [31:0]         fin_val;
    logic                       fin_sat;

    assign accept   = start && !busy;
    assign busy     = (r_state != kvl_pkg::S_IDLE);
    assign rot_last = (r_cnt == kvl_pkg::KEY_IW'(kvl_pkg::MAX_KEYS - 1));
    assign cnt_last = (r_cnt == kvl_pkg::KEY_IW'(r_count - 1'b1));

    kvl_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (chain_ctl),
        .o_head (head)
    );

    kvl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({dtq_mag, 16'h0000}),
        .i_den   (dt_mag),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // segment length and query offset
    assign dt      = $signed({1'b0, r_p1.ktime}) - $signed({1'b0, r_p0.ktime});
    assign dtq     = $signed({1'b0, r_t}) - $signed({1'b0, r_p0.ktime});
    assign dt_mag  = dt[32]  ? 32'(-dt)  : dt[31:0];
    assign dtq_mag = dtq[32] ? 32'(-dtq) : dtq[31:0];

    // pick the axis under work
    always_comb begin
        case (r_ax)
            kvl_pkg::AX_X: begin
                ax_p0 = r_p0.kx;
                ax_p1 = r_p1.kx;
            end
            kvl_pkg::AX_Y: begin
                ax_p0 = r_p0.ky;
                ax_p1 = r_p1.ky;
            end
            default: begin
                ax_p0 = r_p0.kz;
                ax_p1 = r_p1.kz;
            end
        endcase
    end

    assign ax_d   = 33'(ax_p1) - 33'(ax_p0);
    assign ax_a   = ax_d[32] ? 32'(-ax_d) : ax_d[31:0];
    assign ax_neg = ax_d[32] ^ r_negf;
    assign mul_b  = (r_ph == kvl_pkg::PH_LO) ? r_b[23:0] : r_b[47:24];

    // round toward zero, add start point, saturate
    always_comb begin
        fin_big = (r_acc[79:56] != '0);
        fin_sum = 42'(ax_p0) + (ax_neg ? -$signed({2'b00, r_acc[55:16]})
                                       :  $signed({2'b00, r_acc[55:16]}));
        fin_sat = 1'b0;
        fin_val = fin_sum[31:0];
        if (fin_big) begin
            fin_sat = 1'b1;
            fin_val = ax_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (fin_sum[41:31] != {11{fin_sum[41]}}) begin
            fin_sat = 1'b1;
            fin_val = fin_sum[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    end

    // result of a beat answered straight from idle
    always_comb begin
        n_res = '{out_x: '0, out_y: '0, out_z: '0,
                  segment: '0, status: kvl_pkg::ST_OK};
        if (i_cmd.opcode == kvl_pkg::OP_APPEND) begin
            if (!chain_ctl.load) n_res.status = kvl_pkg::ST_FULL;
        end else if (r_count == '0) begin
            n_res.status = kvl_pkg::ST_EMPTY;
        end else if (r_count == kvl_pkg::KEY_CW'(1)) begin
            n_res.out_x = head.kx;
            n_res.out_y = head.ky;
            n_res.out_z = head.kz;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kvl_pkg::S_IDLE: begin
                if (accept && i_cmd.opcode == kvl_pkg::OP_SAMPLE &&
                    r_count > kvl_pkg::KEY_CW'(1)) begin
                    n_state = kvl_pkg::S_ROT;
                end
            end
            kvl_pkg::S_ROT: begin
                if (rot_last) n_state = kvl_pkg::S_PREP;
            end
            kvl_pkg::S_PREP: begin
                n_state = (dt == '0) ? kvl_pkg::S_IDLE : kvl_pkg::S_DIV;
            end
            kvl_pkg::S_DIV: begin
                if (div_done) n_state = kvl_pkg::S_MUL;
            end
            kvl_pkg::S_MUL: begin
                if (r_ax == kvl_pkg::AX_Z && r_ph == kvl_pkg::PH_FIN) begin
                    n_state = kvl_pkg::S_IDLE;
                end
            end
            default: n_state = kvl_pkg::S_IDLE;
        endcase
    end

    // chain and divider controls
    always_comb begin
        chain_ctl.shift = (r_state == kvl_pkg::S_ROT);
        chain_ctl.load  = (r_state == kvl_pkg::S_IDLE) && accept &&
                          (i_cmd.opcode == kvl_pkg::OP_APPEND) &&
                          (r_count < kvl_pkg::KEY_CW'(kvl_pkg::MAX_KEYS));
        chain_ctl.idx   = kvl_pkg::KEY_IW'(r_count);
        chain_ctl.data  = '{ktime: i_cmd.time_req, kx: i_cmd.in_x,
                            ky: i_cmd.in_y, kz: i_cmd.in_z};
        div_start       = (r_state == kvl_pkg::S_PREP) && (dt != '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kvl_pkg::S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
            r_ax     <= kvl_pkg::AX_X;
            r_ph     <= kvl_pkg::PH_LO;
        end else begin
            r_state  <= n_state;
            case (r_state)
                kvl_pkg::S_IDLE: begin
                    r_strobe <= accept && (n_state == kvl_pkg::S_IDLE);
                    if (accept) begin
                        r_found  <= 1'b0;
                        r_cnt    <= '0;
                        if (chain_ctl.load) r_count <= r_count + 1'b1;
                    end
                end
                kvl_pkg::S_ROT: begin
                    r_strobe <= 1'b0;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt != '0 && !r_found && (r_t < head.ktime || cnt_last)) begin
                        r_found <= 1'b1;
                    end
                end
                kvl_pkg::S_PREP: begin
                    r_strobe <= (dt == '0);
                end
                kvl_pkg::S_DIV: begin
                    r_strobe <= 1'b0;
                    r_ax     <= kvl_pkg::AX_X;
                    r_ph     <= kvl_pkg::PH_LO;
                end
                kvl_pkg::S_MUL: begin
                    r_strobe <= (r_ph == kvl_pkg::PH_FIN) && (r_ax == kvl_pkg::AX_Z);
                    r_ph     <= r_ph + 1'b1;
                    if (r_ph == kvl_pkg::PH_FIN) begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                default: r_strobe <= 1'b0;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            kvl_pkg::S_IDLE: begin
                r_t   <= i_cmd.time_req;
                r_sat <= 1'b0;
                if (accept) begin
                    r_res <= n_res;
                end
            end
            kvl_pkg::S_ROT: begin
                // latch the segment ends as they pass the head
                r_prev <= head;
                if (r_cnt != '0 && !r_found && (r_t < head.ktime || cnt_last)) begin
                    r_p0  <= r_prev;
                    r_p1  <= head;
                    r_seg <= r_cnt - 1'b1;
                end
            end
            kvl_pkg::S_PREP: begin
                r_negf          <= dt[32] ^ dtq[32];
                r_res.segment   <= 6'(r_seg);
                if (dt == '0) begin
                    r_res.out_x  <= r_p0.kx;
                    r_res.out_y  <= r_p0.ky;
                    r_res.out_z  <= r_p0.kz;
                    r_res.status <= kvl_pkg::ST_ZERO_INT;
                end
            end
            kvl_pkg::S_DIV: begin
                r_b <= div_quo;
            end
            kvl_pkg::S_MUL: begin
                // two partial products per axis, then finish
                case (r_ph)
                    kvl_pkg::PH_LO: r_pp <= ax_a * mul_b;
                    kvl_pkg::PH_HI: begin
                        r_acc <= {24'h0, r_pp};
                        r_pp  <= ax_a * mul_b;
                    end
                    kvl_pkg::PH_ACC: r_acc <= r_acc + {r_pp, 24'h0};
                    default: begin
                        case (r_ax)
                            kvl_pkg::AX_X: r_res.out_x <= fin_val;
                            kvl_pkg::AX_Y: r_res.out_y <= fin_val;
                            default:       r_res.out_z <= fin_val;
                        endcase
                        r_sat <= r_sat | fin_sat;
                        if (r_ax == kvl_pkg::AX_Z) begin
                            r_res.status <= (r_sat | fin_sat) ? kvl_pkg::ST_SAT
                                                              : kvl_pkg::ST_OK;
                        end
                    end
                endcase
            end
            default: r_t <= r_t;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == kvl_pkg::S_IDLE)
        else $error("result beat outside idle");

    a_rot_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvl_pkg::S_ROT && rot_last) |=> r_state == kvl_pkg::S_PREP)
        else $error("rotation did not end after a full turn");

    a_seg_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kvl_pkg::S_PREP |-> r_found)
        else $error("no segment latched during rotation");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kvl_pkg::KEY_CW'(kvl_pkg::MAX_KEYS))
        else $error("key count past table size");
`endif

endmodule

FILE: src/kvl_cell.sv
module kvl_cell (
    input  logic                i_clk,
    input  kvl_pkg::t_chain_ctl i_ctl,
    input  logic                i_sel,
    input  kvl_pkg::t_key       i_next,
    output kvl_pkg::t_key       o_key
);

    kvl_pkg::t_key r_key;

    // load a new keyframe, or take the neighbor's key on a rotate
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_sel) begin
            r_key <= i_ctl.data;
        end else if (i_ctl.shift) begin
            r_key <= i_next;
        end
    end

    assign o_key = r_key;

endmodule

FILE: src/kvl_chain.sv
module kvl_chain (
    input  logic                i_clk,
    input  kvl_pkg::t_chain_ctl i_ctl,
    output kvl_pkg::t_key       o_head
);

    kvl_pkg::t_key keys [kvl_pkg::MAX_KEYS];

    // ring of cells, each passes its key toward the head
    for (genvar k = 0; k < kvl_pkg::MAX_KEYS; k++) begin : g_cell
        kvl_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_sel  (i_ctl.idx == kvl_pkg::KEY_IW'(k)),
            .i_next (keys[(k + 1) % kvl_pkg::MAX_KEYS]),
            .o_key  (keys[k])
        );
    end

    assign o_head = keys[0];

endmodule

FILE: src/kvl_div.sv
module kvl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [kvl_pkg::DIV_NW-1:0] i_num,
    input  logic [kvl_pkg::DIV_DW-1:0] i_den,
    output logic                       o_done,
    output logic [kvl_pkg::DIV_NW-1:0] o_quo
);

    logic                       r_busy;
    logic                       r_done;
    logic [kvl_pkg::DIV_CW-1:0] r_cnt;
    logic [kvl_pkg::DIV_DW-1:0] r_rem;
    logic [kvl_pkg::DIV_DW-1:0] r_den;
    logic [kvl_pkg::DIV_NW-1:0] r_quo;
    logic [kvl_pkg::DIV_DW+1:0] trial;

    // trial subtract of one quotient bit
    assign trial = {1'b0, r_rem, r_quo[kvl_pkg::DIV_NW-1]} - {2'b00, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == kvl_pkg::DIV_CW'(kvl_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            if (!trial[kvl_pkg::DIV_DW+1]) begin
                r_rem <= trial[kvl_pkg::DIV_DW-1:0];
                r_quo <= {r_quo[kvl_pkg::DIV_NW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[kvl_pkg::DIV_DW-2:0], r_quo[kvl_pkg::DIV_NW-1]};
                r_quo <= {r_quo[kvl_pkg::DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: tb/keyframe_vec3_lerp_top_tb.sv
class lerp_scoreboard;
    logic [31:0]        key_t [64];
    logic signed [31:0] key_x [64];
    logic signed [31:0] key_y [64];
    logic signed [31:0] key_z [64];
    int                 key_n;
    kvl_pkg::t_res      pending_pos [$];
    int                 mismatches;

    function new();
        key_n      = 0;
        mismatches = 0;
    endfunction

    // move p0 toward p1 by a Q16.16 factor, saturate to int32
    function automatic logic signed [31:0] lerp_axis(logic signed [31:0] p0,
            logic signed [31:0] p1, longint factor, inout bit sat);
        longint       d;
        bit           neg;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] prod;
        longint       mag;
        longint       sum;
        d    = longint'(p1) - longint'(p0);
        neg  = (d < 0) != (factor < 0);
        a    = 128'(d < 0 ? -d : d);
        b    = 128'(factor < 0 ? -factor : factor);
        prod = a * b;
        if (prod[127:56] != 0) begin
            sat = 1;
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        mag = longint'(prod[63:16]);
        sum = longint'(p0) + (neg ? -mag : mag);
        if (sum > 64'sd2147483647) begin
            sat = 1;
            return 32'sh7fff_ffff;
        end
        if (sum < -64'sd2147483648) begin
            sat = 1;
            return 32'sh8000_0000;
        end
        return sum[31:0];
    endfunction

    // note an accepted command beat and queue the position it must yield
    function void note_cmd(kvl_pkg::t_cmd c);
        kvl_pkg::t_res r;
        int            seg;
        longint        dt;
        longint        dtq;
        longint        factor;
        bit            sat;
        r   = '0;
        sat = 0;
        seg = 0;
        if (c.opcode == kvl_pkg::OP_APPEND) begin
            if (key_n < 64) begin
                key_t[key_n] = c.time_req;
                key_x[key_n] = c.in_x;
                key_y[key_n] = c.in_y;
                key_z[key_n] = c.in_z;
                key_n++;
                r.status = kvl_pkg::ST_OK;
            end else begin
                r.status = kvl_pkg::ST_FULL;
            end
        end else if (key_n == 0) begin
            r.status = kvl_pkg::ST_EMPTY;
        end else if (key_n == 1) begin
            r.out_x = key_x[0];
            r.out_y = key_y[0];
            r.out_z = key_z[0];
            r.status = kvl_pkg::ST_OK;
        end else begin
            seg = key_n - 2;
            for (int j = 0; j + 1 < key_n; j++) begin
                if (c.time_req < key_t[j + 1]) begin
                    seg = j;
                    break;
                end
            end
            r.segment = seg[5:0];
            dt = longint'(key_t[seg + 1]) - longint'(key_t[seg]);
            if (dt == 0) begin
                r.out_x  = key_x[seg];
                r.out_y  = key_y[seg];
                r.out_z  = key_z[seg];
                r.status = kvl_pkg::ST_ZERO_INT;
            end else begin
                dtq    = longint'(c.time_req) - longint'(key_t[seg]);
                factor = (dtq * 65536) / dt;
                r.out_x = lerp_axis(key_x[seg], key_x[seg + 1], factor, sat);
                r.out_y = lerp_axis(key_y[seg], key_y[seg + 1], factor, sat);
                r.out_z = lerp_axis(key_z[seg], key_z[seg + 1], factor, sat);
                r.status = sat ? kvl_pkg::ST_SAT : kvl_pkg::ST_OK;
            end
        end
        pending_pos.insert(pending_pos.size(), r);
    endfunction

    // compare one result beat against the oldest expectation
    function void check_res(kvl_pkg::t_res got);
        kvl_pkg::t_res want;
        if (pending_pos.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat %h", got);
            return;
        end
        want = pending_pos.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                got.out_z !== want.out_z || got.segment !== want.segment ||
                got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result: exp x=%h y=%h z=%h seg=%0d st=%0d",
                          " got x=%h y=%h z=%h seg=%0d st=%0d"},
                    want.out_x, want.out_y, want.out_z, want.segment, want.status,
                    got.out_x, got.out_y, got.out_z, got.segment, got.status);
        end
    endfunction
endclass

module keyframe_vec3_lerp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    kvl_pkg::t_cmd  i_cmd;
    logic           o_strobe;
    kvl_pkg::t_res  o_res;

    lerp_scoreboard sb;
    logic [31:0]    last_time;

    keyframe_vec3_lerp_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // take every strobed result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_res(o_res);
    end

    // hold off a random gap, then offer one beat until it is taken
    task automatic send_cmd(logic op, logic [31:0] t, logic [31:0] x, logic [31:0] y,
            logic [31:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd.opcode   <= op;
        i_cmd.time_req <= t;
        i_cmd.in_x     <= x;
        i_cmd.in_y     <= y;
        i_cmd.in_z     <= z;
        do @(posedge i_clk); while (busy);
        sb.note_cmd('{op, t, x, y, z});
    endtask

    task automatic add_key(logic [31:0] t, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_cmd(kvl_pkg::OP_APPEND, t, x, y, z);
        last_time = t;
    endtask

    task automatic sample_at(logic [31:0] t);
        send_cmd(kvl_pkg::OP_SAMPLE, t, $urandom, $urandom, $urandom);
    endtask

    initial begin
        #20_000_000;
        $display("keyframe_vec3_lerp_top: mismatch");
        $finish;
    end

    initial begin
        int          n;
        int          waited;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        sb        = new();
        last_time = '0;
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_cmd     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, single key, zero interval, extremes, saturation
        sample_at(32'h0001_0000);
        add_key(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000);
        sample_at(32'h0000_0000);
        sample_at(32'hffff_ffff);
        add_key(32'h0001_0000, 32'h0005_0000, 32'h0000_0000, 32'h0001_0000);
        sample_at(32'h0000_8000);
        sample_at(32'h0002_0000);
        add_key(32'h0003_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
        sample_at(32'h0002_0000);
        sample_at(32'h0001_0001);
        sample_at(32'hffff_ffff);
        sample_at(32'h0000_0000);
        add_key(32'h0003_0001, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        sample_at(32'h0003_0000);
        sample_at(32'h0010_0000);
        add_key(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        sample_at(32'h0003_0002);
        sample_at(32'h7fff_ffff);
        add_key(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff);
        sample_at(32'h8000_0000);
        sample_at(32'hffff_fffe);
        sample_at(32'hffff_ffff);

        // random: ascending keys with random content, samples, some noise
        last_time = $urandom_range(0, 32'h0004_0000);
        for (n = 0; n < 1530; n++) begin
            if (sb.key_n < 64 ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 19) == 0)) begin
                if ($urandom_range(0, 3) == 0) begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end else begin
                    x = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
                    y = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
                    z = 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
                end
                case ($urandom_range(0, 9))
                    0:       add_key(last_time, x, y, z);
                    1:       add_key($urandom, x, y, z);
                    default: add_key(last_time + $urandom_range(1, 32'h0004_0000), x, y, z);
                endcase
            end else begin
                case ($urandom_range(0, 4))
                    0:       sample_at($urandom);
                    1:       sample_at(sb.key_t[$urandom_range(0, sb.key_n > 0 ? sb.key_n - 1 : 0)]);
                    default: sample_at(last_time - $urandom_range(0, 32'h00a0_0000));
                endcase
            end
        end

        // drop start right at the last accepted beat
        start <= 1'b0;
        waited = 0;
        while (sb.pending_pos.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_pos.size() == 0)
            $display("keyframe_vec3_lerp_top: match");
        else
            $display("keyframe_vec3_lerp_top: mismatch");
        $finish;
    end
endmodule
